FILE: rtl/e2q_pkg.sv
package e2q_pkg;

    localparam int TableLen = 24;
    localparam int CordicStepsDefault = 16;
    localparam int AngleW = 17;
    localparam int QuatW = 16;
    localparam int QW = 33;
    localparam int ZW = 33;
    localparam int HalfTurn = 92160;
    localparam int Quarter = 23040;
    localparam logic [32:0] DegToRadQ46 = 33'd4797524517;
    localparam logic signed [QW-1:0] CordicGain = 33'sd652032874;
    localparam int Q15Max = 32767;

    typedef logic [1:0] quad_t;

    typedef struct packed {
        logic signed [QW-1:0] s;
        logic signed [QW-1:0] c;
    } sincos_t;

    typedef struct packed {
        logic signed [QuatW-1:0] x;
        logic signed [QuatW-1:0] y;
        logic signed [QuatW-1:0] z;
        logic signed [QuatW-1:0] w;
    } quat_t;

    function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        unique case (i)
            5'd0: r = 33'sd843314856;
            5'd1: r = 33'sd497837829;
            5'd2: r = 33'sd263043836;
            5'd3: r = 33'sd133525158;
            5'd4: r = 33'sd67021686;
            5'd5: r = 33'sd33543515;
            5'd6: r = 33'sd16775850;
            5'd7: r = 33'sd8388437;
            5'd8: r = 33'sd4194282;
            5'd9: r = 33'sd2097149;
            5'd10: r = 33'sd1048575;
            5'd11: r = 33'sd524287;
            5'd12: r = 33'sd262143;
            5'd13: r = 33'sd131071;
            5'd14: r = 33'sd65535;
            5'd15: r = 33'sd32767;
            5'd16: r = 33'sd16383;
            5'd17: r = 33'sd8191;
            5'd18: r = 33'sd4095;
            5'd19: r = 33'sd2047;
            5'd20: r = 33'sd1023;
            5'd21: r = 33'sd511;
            5'd22: r = 33'sd255;
            5'd23: r = 33'sd127;
            default: r = '0;
        endcase
        return r;
    endfunction

    // q30 product, round to nearest, ties away from zero
    function automatic logic signed [QW-1:0] mul_q30(input logic signed [QW-1:0] a,
                                                     input logic signed [QW-1:0] b);
        logic [QW-1:0] ma;
        logic [QW-1:0] mb;
        logic [2*QW-1:0] p;
        logic [QW-1:0] r;
        ma = a[QW-1] ? QW'(-a) : QW'(a);
        mb = b[QW-1] ? QW'(-b) : QW'(b);
        p = ma * mb + (2*QW)'(64'd536870912);
        r = p[30+QW-1:30];
        return (a[QW-1] ^ b[QW-1]) ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [QuatW-1:0] to_q15(input logic signed [QW+1:0] v);
        logic [QW+1:0] m;
        logic [QW+1:0] r;
        m = v[QW+1] ? (QW+2)'(-v) : (QW+2)'(v);
        r = (m + (QW+2)'(16384)) >> 15;
        if (r > (QW+2)'(Q15Max))
            r = (QW+2)'(Q15Max);
        return v[QW+1] ? QuatW'(-r) : QuatW'(r);
    endfunction

endpackage

FILE: rtl/e2q_if.sv
interface e2q_if #(parameter int W = 1) ();
    logic valid;
    logic ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/e2q_lane.sv
module e2q_lane
    import e2q_pkg::*;
#(
    parameter int CordicSteps = CordicStepsDefault
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [AngleW-1:0] angle,
    output sincos_t                  result
);

    localparam int Steps = (CordicSteps > TableLen) ? TableLen : CordicSteps;

    logic [16:0] u_reg;
    logic [16:0] u_next;
    logic [16:0] rem;
    quad_t quad;
    quad_t quad_pipe_reg [Steps+1];
    logic signed [ZW-1:0] z0_reg;
    logic signed [QW-1:0] x_reg [Steps+1];
    logic signed [QW-1:0] y_reg [Steps+1];
    logic signed [ZW-1:0] z_reg [Steps+1];
    logic [49:0] prod;

    // wrap half angle into one turn
    always_comb
    begin
        logic signed [18:0] t;
        t = 19'(angle) + 19'(HalfTurn);
        if (t >= 19'(HalfTurn))
            t = t - 19'(HalfTurn);
        u_next = t[16:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            u_reg <= u_next;
    end

    always_comb
    begin
        if (u_reg >= 17'(3*Quarter))
        begin
            quad = 2'd3;
            rem = u_reg - 17'(3*Quarter);
        end
        else if (u_reg >= 17'(2*Quarter))
        begin
            quad = 2'd2;
            rem = u_reg - 17'(2*Quarter);
        end
        else if (u_reg >= 17'(Quarter))
        begin
            quad = 2'd1;
            rem = u_reg - 17'(Quarter);
        end
        else
        begin
            quad = 2'd0;
            rem = u_reg;
        end
    end

    assign prod = 50'(rem) * 50'(DegToRadQ46) + 50'd32768;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z0_reg <= $signed(ZW'(prod[49:16]));
            quad_pipe_reg[0] <= quad;
        end
    end

    assign x_reg[0] = CordicGain;
    assign y_reg[0] = '0;
    assign z_reg[0] = z0_reg;

    for (genvar i = 0; i < Steps; i++) begin : g_step
        logic signed [QW-1:0] xs_reg;
        logic signed [QW-1:0] ys_reg;
        logic signed [ZW-1:0] zs_reg;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][ZW-1])
                begin
                    xs_reg <= x_reg[i] - (y_reg[i] >>> i);
                    ys_reg <= y_reg[i] + (x_reg[i] >>> i);
                    zs_reg <= z_reg[i] - atan_q30(5'(i));
                end
                else
                begin
                    xs_reg <= x_reg[i] + (y_reg[i] >>> i);
                    ys_reg <= y_reg[i] - (x_reg[i] >>> i);
                    zs_reg <= z_reg[i] + atan_q30(5'(i));
                end
                quad_pipe_reg[i+1] <= quad_pipe_reg[i];
            end
        end
        assign x_reg[i+1] = xs_reg;
        assign y_reg[i+1] = ys_reg;
        assign z_reg[i+1] = zs_reg;
    end

    always_comb
    begin
        unique case (quad_pipe_reg[Steps])
            2'd0: begin result.c = x_reg[Steps]; result.s = y_reg[Steps]; end
            2'd1: begin result.c = -y_reg[Steps]; result.s = x_reg[Steps]; end
            2'd2: begin result.c = -x_reg[Steps]; result.s = -y_reg[Steps]; end
            default: begin result.c = y_reg[Steps]; result.s = -x_reg[Steps]; end
        endcase
    end

endmodule

FILE: rtl/e2q_merge.sv
module e2q_merge
    import e2q_pkg::*;
(
    input  logic    clk,
    input  logic    en,
    input  sincos_t p,
    input  sincos_t yw,
    input  sincos_t r,
    output quat_t   q
);

    logic signed [QW-1:0] crcp_reg, srsp_reg, srcp_reg, crsp_reg;
    logic signed [QW-1:0] sy_reg, cy_reg;
    logic signed [QW-1:0] t_reg [8];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            crcp_reg <= mul_q30(r.c, p.c);
            srsp_reg <= mul_q30(r.s, p.s);
            srcp_reg <= mul_q30(r.s, p.c);
            crsp_reg <= mul_q30(r.c, p.s);
            sy_reg <= yw.s;
            cy_reg <= yw.c;
            t_reg[0] <= mul_q30(srcp_reg, cy_reg);
            t_reg[1] <= mul_q30(crsp_reg, sy_reg);
            t_reg[2] <= mul_q30(crsp_reg, cy_reg);
            t_reg[3] <= mul_q30(srcp_reg, sy_reg);
            t_reg[4] <= mul_q30(crcp_reg, sy_reg);
            t_reg[5] <= mul_q30(srsp_reg, cy_reg);
            t_reg[6] <= mul_q30(crcp_reg, cy_reg);
            t_reg[7] <= mul_q30(srsp_reg, sy_reg);
            q.x <= to_q15((QW+2)'(t_reg[0]) - (QW+2)'(t_reg[1]));
            q.y <= to_q15((QW+2)'(t_reg[2]) + (QW+2)'(t_reg[3]));
            q.z <= to_q15((QW+2)'(t_reg[4]) - (QW+2)'(t_reg[5]));
            q.w <= to_q15((QW+2)'(t_reg[6]) + (QW+2)'(t_reg[7]));
        end
    end

endmodule

FILE: rtl/euler_to_quaternion.sv
// Euler angles (pitch, yaw, roll, degrees times 128) in, unit quaternion
// (x, y, z, w) in Q1.15 out. One transfer per cycle is accepted unless the
// output stalls. Two angle-reduction stages and the unrolled CORDIC
// pipeline in each of the three angle lanes are followed by three product
// stages. The whole pipeline advances only when its last stage is empty or
// being taken, so a stalled output holds everything behind it.
module euler_to_quaternion
    import e2q_pkg::*;
#(
    parameter int CORDIC_STEPS = CordicStepsDefault
) (
    input logic clk,
    input logic rst_n,
    e2q_if.sink   in_ch,
    e2q_if.source out_ch
);

    localparam int Steps = (CORDIC_STEPS > TableLen) ? TableLen : CORDIC_STEPS;
    localparam int Depth = Steps + 5;

    logic [Depth-1:0] vld_reg;
    logic en;
    sincos_t sc_p, sc_y, sc_r;
    quat_t q;

    assign en = !vld_reg[Depth-1] || out_ch.ready;
    assign in_ch.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[Depth-2:0], in_ch.valid};
    end

    e2q_lane #(.CordicSteps(CORDIC_STEPS)) u_pitch (
        .clk(clk), .en(en),
        .angle(in_ch.data[3*AngleW-1:2*AngleW]), .result(sc_p));
    e2q_lane #(.CordicSteps(CORDIC_STEPS)) u_yaw (
        .clk(clk), .en(en),
        .angle(in_ch.data[2*AngleW-1:AngleW]), .result(sc_y));
    e2q_lane #(.CordicSteps(CORDIC_STEPS)) u_roll (
        .clk(clk), .en(en),
        .angle(in_ch.data[AngleW-1:0]), .result(sc_r));

    e2q_merge u_merge (
        .clk(clk), .en(en), .p(sc_p), .yw(sc_y), .r(sc_r), .q(q));

    assign out_ch.valid = vld_reg[Depth-1];
    assign out_ch.data = q;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid)
        else $error("result dropped under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_ch.valid |-> in_ch.ready)
        else $error("input blocked with empty output");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> vld_reg[0])
        else $error("accepted transfer lost");

endmodule

FILE: tb/sv/euler_to_quaternion_tb.sv
`timescale 1ns / 1ps

module euler_to_quaternion_tb;
    import e2q_pkg::*;

    typedef struct packed {
        logic signed [AngleW-1:0] pitch;
        logic signed [AngleW-1:0] yaw;
        logic signed [AngleW-1:0] roll;
    } euler_t;

    localparam int Steps = CordicStepsDefault;
    localparam int Latency = Steps + 6;
    localparam int MaxAngle = 46080;

    logic clk;
    logic rst_n;
    e2q_if #(.W($bits(euler_t))) in_ch ();
    e2q_if #(.W($bits(quat_t))) out_ch ();

    euler_to_quaternion dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    quat_t expected_quats[$];
    int errors = 0;
    int burst_left = 0;
    int stall_period = 5;
    int stall_phase = 0;
    bit stall_off = 0;

    longint atan_tab[24] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767, 16383, 8191,
        4095, 2047, 1023, 511, 255, 127
    };

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic longint round_mul(longint a, longint b);
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned p;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        p = (ma * mb + 64'd536870912) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic void half_angle_trig(input logic signed [AngleW-1:0] ang,
                                            output longint s, output longint c);
        longint u;
        longint rem;
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        int quad;
        u = (longint'(ang) + HalfTurn) % HalfTurn;
        quad = int'(u / Quarter) & 3;
        rem = u % Quarter;
        z = (rem * 64'd4797524517 + 32768) >>> 16;
        x = 652032874;
        y = 0;
        for (int i = 0; i < Steps && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= atan_tab[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += atan_tab[i];
            end
        end
        case (quad)
            0: begin c = x; s = y; end
            1: begin c = -y; s = x; end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic logic signed [QuatW-1:0] sat_q15(longint v);
        longint unsigned m;
        m = (((v < 0) ? -v : v) + 16384) >> 15;
        if (m > Q15Max)
            m = Q15Max;
        return (v < 0) ? QuatW'(-longint'(m)) : QuatW'(m);
    endfunction

    function automatic quat_t predict_quat(euler_t e);
        longint sp, cp, sy, cy, sr, cr;
        longint crcp, srsp, srcp, crsp;
        quat_t q;
        half_angle_trig(e.pitch, sp, cp);
        half_angle_trig(e.yaw, sy, cy);
        half_angle_trig(e.roll, sr, cr);
        crcp = round_mul(cr, cp);
        srsp = round_mul(sr, sp);
        srcp = round_mul(sr, cp);
        crsp = round_mul(cr, sp);
        q.x = sat_q15(round_mul(srcp, cy) - round_mul(crsp, sy));
        q.y = sat_q15(round_mul(crsp, cy) + round_mul(srcp, sy));
        q.z = sat_q15(round_mul(crcp, sy) - round_mul(srsp, cy));
        q.w = sat_q15(round_mul(crcp, cy) + round_mul(srsp, sy));
        return q;
    endfunction

    // bursts of random length with random gaps
    task automatic send_angles(input euler_t e);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.data <= e;
        do
            @(posedge clk);
        while (!in_ch.ready);
        expected_quats.push_back(predict_quat(e));
    endtask

    function automatic euler_t make_euler(int p, int y, int r);
        euler_t e;
        e.pitch = AngleW'(p);
        e.yaw = AngleW'(y);
        e.roll = AngleW'(r);
        return e;
    endfunction

    function automatic int rand_range_angle();
        return $urandom_range(0, 2 * MaxAngle) - MaxAngle;
    endfunction

    function automatic int rand_full_angle();
        return $urandom_range(0, 131071) - 65536;
    endfunction

    task automatic test_single_axes();
        send_angles(make_euler(0, 0, 0));
        send_angles(make_euler(11520, 0, 0));
        send_angles(make_euler(0, 11520, 0));
        send_angles(make_euler(0, 0, 11520));
        send_angles(make_euler(-11520, -11520, -11520));
        send_angles(make_euler(5760, 17280, -2880));
    endtask

    task automatic test_field_extremes();
        send_angles(make_euler(MaxAngle, MaxAngle, MaxAngle));
        send_angles(make_euler(-MaxAngle, -MaxAngle, -MaxAngle));
        send_angles(make_euler(MaxAngle, -MaxAngle, 0));
        send_angles(make_euler(65535, 65535, 65535));
        send_angles(make_euler(-65536, -65536, -65536));
        send_angles(make_euler(65535, -65536, 1));
        send_angles(make_euler(1, -1, 0));
    endtask

    // half angle crossing quadrant and full-turn boundaries
    task automatic test_quadrant_edges();
        send_angles(make_euler(Quarter, Quarter - 1, Quarter + 1));
        send_angles(make_euler(2 * Quarter, 2 * Quarter - 1, 2 * Quarter + 1));
        send_angles(make_euler(3 * Quarter, 3 * Quarter - 1, -Quarter));
        send_angles(make_euler(-2 * Quarter, -3 * Quarter, -Quarter + 1));
        send_angles(make_euler(HalfTurn - 65536 - 1, 0, 65535));
        send_angles(make_euler(-Quarter - 1, 2 * Quarter + 1, -2 * Quarter - 1));
    endtask

    task automatic test_random_in_range(int n);
        for (int i = 0; i < n; i++)
            send_angles(make_euler(rand_range_angle(), rand_range_angle(),
                                   rand_range_angle()));
    endtask

    task automatic test_random_wrapped(int n);
        for (int i = 0; i < n; i++)
            send_angles(make_euler(rand_full_angle(), rand_full_angle(),
                                   rand_full_angle()));
    endtask

    // receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            if (stall_phase >= stall_period - 1)
            begin
                stall_phase <= 0;
                stall_period <= $urandom_range(2, 12);
                stall_off <= ($urandom_range(0, 3) == 0);
            end
            else
                stall_phase <= stall_phase + 1;
            out_ch.ready <= stall_off || (stall_phase < stall_period / 2) ||
                            ($urandom_range(0, 1) == 1);
        end
    end

    always @(posedge clk)
    begin
        quat_t got;
        quat_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (expected_quats.size() == 0)
            begin
                $display("%0t: unexpected transfer %h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_quats.pop_front();
                if (got.x !== want.x)
                    $display("%0t: quat_x expected %0d actual %0d", $time, want.x, got.x);
                if (got.y !== want.y)
                    $display("%0t: quat_y expected %0d actual %0d", $time, want.y, got.y);
                if (got.z !== want.z)
                    $display("%0t: quat_z expected %0d actual %0d", $time, want.z, got.z);
                if (got.w !== want.w)
                    $display("%0t: quat_w expected %0d actual %0d", $time, want.w, got.w);
                if (got !== want)
                    errors++;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_axes();
        test_field_extremes();
        test_quadrant_edges();
        test_random_in_range(400);
        test_random_wrapped(250);
        in_ch.valid <= 1'b0;
        while (expected_quats.size() != 0)
            @(posedge clk);
        repeat (Latency + 10) @(posedge clk);
        if (errors == 0 && expected_quats.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: euler_to_quaternion.f
rtl/e2q_pkg.sv
rtl/e2q_if.sv
rtl/e2q_lane.sv
rtl/e2q_merge.sv
rtl/euler_to_quaternion.sv
tb/sv/euler_to_quaternion_tb.sv
